// File: hdl/hpc_pkg.sv
// Shared constants, codes and controller/datapath interface types of the hashed probe cache.
package hpc_pkg;

  // Slot count must be a power of two: the home slot is the low hash bits.
  localparam int CACHE_SLOTS  = 64;
  localparam int PROBE_WINDOW = 8;
  localparam int TEXT_BYTES   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int KEY_ROOM     = HEADER_BYTES + TEXT_BYTES;
  localparam int KEY_LIMIT    = KEY_ROOM - 1;

  localparam int SLOT_W = $clog2(CACHE_SLOTS);
  localparam int LEN_W  = $clog2(KEY_ROOM);
  localparam int PR_W   = $clog2(PROBE_WINDOW + 1);
  localparam int KB_AW  = $clog2(CACHE_SLOTS * KEY_ROOM);
  localparam int META_W = 32 + LEN_W;
  localparam int PAY_W  = 63;
  localparam int OUT_SLOT_W = 6;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    ACT_KEY   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_CLAIM = 2'd2,
    ACT_SET   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_CLAIM = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic  key_load;
    logic  set_load;
    logic  op_start;
    kind_e kind;
    logic  advance;
    logic  j_clear;
    logic  j_inc;
    logic  hit_take;
    logic  lru_init;
    logic  lru_step;
    logic  ev_check;
    logic  claim_write;
    logic  copy_step;
    logic  res_load;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic used_cur;
    logic probe_end;
    logic lru_last;
    logic meta_match;
    logic j_end;
    logic byte_eq;
    logic copy_done;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/hpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hpc_datapath.sv
// Datapath: key hashing and buffering, slot stores, probe counters and result registers.
module hpc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          key_byte_i,
  input  logic [31:0]         frame_i,
  input  logic [5:0]          slot_i,
  input  logic [31:0]         buffer_id_i,
  input  logic [30:0]         vertex_count_i,
  input  hpc_pkg::cmd_t       cmd_i,
  output hpc_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_kind_o,
  output logic                out_hit_o,
  output logic [5:0]          out_slot_o,
  output logic [31:0]         out_buf_o,
  output logic [30:0]         out_vc_o,
  output logic                out_ev_valid_o,
  output logic [31:0]         out_ev_buf_o
);

  logic [31:0]                      hash_q, hash_d;
  logic [hpc_pkg::LEN_W-1:0]        len_q, len_d;
  logic                             ovf_q, ovf_d;
  logic                             closed_q;
  logic [hpc_pkg::CACHE_SLOTS-1:0]  used_q;
  logic                             cv_q;
  logic                             out_valid_q;

  logic [31:0]                      frame_q;
  logic [hpc_pkg::SLOT_W-1:0]       slot_q, start_q, pick_q;
  logic [31:0]                      min_q;
  logic [hpc_pkg::PR_W-1:0]         probe_q;
  logic [hpc_pkg::LEN_W-1:0]        j_q, jd_q;

  hpc_pkg::kind_e                   res_kind_q;
  logic                             res_hit_q, res_ev_q;
  logic [5:0]                       res_slot_q;
  logic [31:0]                      res_buf_q, res_evbuf_q;
  logic [30:0]                      res_vc_q;

  logic [1:0]                       out_kind_q;
  logic                             out_hit_q, out_ev_q;
  logic [5:0]                       out_slot_q;
  logic [31:0]                      out_buf_q, out_evbuf_q;
  logic [30:0]                      out_vc_q;

  logic [hpc_pkg::META_W-1:0]       meta_rd;
  logic [31:0]                      frame_rd;
  logic [hpc_pkg::PAY_W-1:0]        pay_rd, pay_wdata;
  logic [7:0]                       kb_rd, pend_rd;
  logic [hpc_pkg::KB_AW-1:0]        kb_base;

  logic [31:0]                      eff_hash;
  logic [hpc_pkg::LEN_W-1:0]        eff_len;
  logic                             eff_ovf, byte_ok, set_ok, pick_new;
  logic [hpc_pkg::SLOT_W-1:0]       set_slot, pay_waddr;

  function automatic logic [5:0] OUT_SLOT_CAST(input logic [hpc_pkg::SLOT_W-1:0] s);
    OUT_SLOT_CAST = hpc_pkg::OUT_SLOT_W'(s);
  endfunction

  // A byte after a find or claim starts a fresh key.
  always_comb begin
    eff_hash = closed_q ? hpc_pkg::FNV_BASIS : hash_q;
    eff_len  = closed_q ? '0 : len_q;
    eff_ovf  = closed_q ? 1'b0 : ovf_q;
    byte_ok  = !eff_ovf && (32'(eff_len) < 32'(hpc_pkg::KEY_LIMIT));
    hash_d   = eff_hash;
    len_d    = eff_len;
    ovf_d    = eff_ovf;
    if (byte_ok) begin
      hash_d = (eff_hash ^ {24'd0, key_byte_i}) * hpc_pkg::FNV_PRIME;
      len_d  = eff_len + 1'b1;
    end else begin
      ovf_d  = 1'b1;
    end
  end

  assign set_slot  = hpc_pkg::SLOT_W'(slot_i);
  assign set_ok    = 32'(slot_i) < 32'(hpc_pkg::CACHE_SLOTS);
  assign pay_waddr = cmd_i.set_load ? set_slot : slot_q;
  assign pay_wdata = cmd_i.set_load ? {vertex_count_i, buffer_id_i} : '0;
  assign kb_base   = hpc_pkg::KB_AW'(slot_q) * hpc_pkg::KB_AW'(hpc_pkg::KEY_ROOM);
  assign pick_new  = (probe_q == '0) || ($signed(frame_rd) < $signed(min_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= hpc_pkg::FNV_BASIS;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b0;
      used_q      <= '0;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.key_load) begin
        hash_q   <= hash_d;
        len_q    <= len_d;
        ovf_q    <= ovf_d;
        closed_q <= 1'b0;
      end
      if (cmd_i.op_start) begin
        closed_q <= 1'b1;
      end
      if (cmd_i.claim_write) begin
        used_q[slot_q] <= 1'b1;
        cv_q           <= 1'b0;
      end
      if (cmd_i.copy_step) begin
        cv_q <= j_q != len_q;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_start) begin
      frame_q     <= frame_i;
      start_q     <= hash_q[hpc_pkg::SLOT_W-1:0];
      slot_q      <= hash_q[hpc_pkg::SLOT_W-1:0];
      probe_q     <= '0;
      res_kind_q  <= cmd_i.kind;
      res_hit_q   <= 1'b0;
      res_slot_q  <= '0;
      res_buf_q   <= '0;
      res_vc_q    <= '0;
      res_ev_q    <= 1'b0;
      res_evbuf_q <= '0;
    end
    if (cmd_i.advance) begin
      probe_q <= probe_q + 1'b1;
      slot_q  <= slot_q + 1'b1;
    end
    if (cmd_i.j_clear) begin
      j_q <= '0;
    end
    if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.hit_take) begin
      res_hit_q  <= 1'b1;
      res_slot_q <= OUT_SLOT_CAST(slot_q);
      res_buf_q  <= pay_rd[31:0];
      res_vc_q   <= pay_rd[62:32];
    end
    if (cmd_i.lru_init) begin
      slot_q  <= start_q;
      probe_q <= '0;
    end
    if (cmd_i.lru_step) begin
      probe_q <= probe_q + 1'b1;
      if (pick_new) begin
        pick_q <= slot_q;
        min_q  <= frame_rd;
      end
      if (probe_q == hpc_pkg::PR_W'(hpc_pkg::PROBE_WINDOW - 1)) begin
        slot_q <= pick_new ? slot_q : pick_q;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
    if (cmd_i.ev_check && used_q[slot_q] && (pay_rd[31:0] != '0)) begin
      res_ev_q    <= 1'b1;
      res_evbuf_q <= pay_rd[31:0];
    end
    if (cmd_i.claim_write) begin
      res_slot_q <= OUT_SLOT_CAST(slot_q);
      j_q        <= '0;
    end
    if (cmd_i.copy_step) begin
      jd_q <= j_q;
      if (j_q != len_q) begin
        j_q <= j_q + 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      out_kind_q  <= res_kind_q;
      out_hit_q   <= res_hit_q;
      out_slot_q  <= res_slot_q;
      out_buf_q   <= res_buf_q;
      out_vc_q    <= res_vc_q;
      out_ev_q    <= res_ev_q;
      out_evbuf_q <= res_evbuf_q;
    end
  end

  hpc_ram #(.WIDTH(hpc_pkg::META_W), .DEPTH(hpc_pkg::CACHE_SLOTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.claim_write),
    .waddr_i (slot_q),
    .wdata_i ({len_q, hash_q}),
    .raddr_i (slot_q),
    .rdata_o (meta_rd)
  );

  hpc_ram #(.WIDTH(32), .DEPTH(hpc_pkg::CACHE_SLOTS)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.claim_write || cmd_i.hit_take),
    .waddr_i (slot_q),
    .wdata_i (frame_q),
    .raddr_i (slot_q),
    .rdata_o (frame_rd)
  );

  hpc_ram #(.WIDTH(hpc_pkg::PAY_W), .DEPTH(hpc_pkg::CACHE_SLOTS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.set_load && set_ok) || cmd_i.claim_write),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .raddr_i (slot_q),
    .rdata_o (pay_rd)
  );

  hpc_ram #(.WIDTH(8), .DEPTH(hpc_pkg::CACHE_SLOTS * hpc_pkg::KEY_ROOM)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cv_q),
    .waddr_i (kb_base + hpc_pkg::KB_AW'(jd_q)),
    .wdata_i (pend_rd),
    .raddr_i (kb_base + hpc_pkg::KB_AW'(j_q)),
    .rdata_o (kb_rd)
  );

  hpc_ram #(.WIDTH(8), .DEPTH(hpc_pkg::KEY_ROOM)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.key_load && byte_ok),
    .waddr_i (eff_len),
    .wdata_i (key_byte_i),
    .raddr_i (j_q),
    .rdata_o (pend_rd)
  );

  assign sts_o.ovf        = ovf_q;
  assign sts_o.used_cur   = used_q[slot_q];
  assign sts_o.probe_end  = probe_q == hpc_pkg::PR_W'(hpc_pkg::PROBE_WINDOW);
  assign sts_o.lru_last   = probe_q == hpc_pkg::PR_W'(hpc_pkg::PROBE_WINDOW - 1);
  assign sts_o.meta_match = meta_rd == {len_q, hash_q};
  assign sts_o.j_end      = j_q == len_q;
  assign sts_o.byte_eq    = kb_rd == pend_rd;
  assign sts_o.copy_done  = (j_q == len_q) && !cv_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_hit_o      = out_hit_q;
  assign out_slot_o     = out_slot_q;
  assign out_buf_o      = out_buf_q;
  assign out_vc_o       = out_vc_q;
  assign out_ev_valid_o = out_ev_q;
  assign out_ev_buf_o   = out_evbuf_q;

`ifndef SYNTH
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= 32'(hpc_pkg::KEY_LIMIT))
    else $error("pending key length beyond limit");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == hpc_pkg::KIND_ERR) |-> !out_hit_q && !out_ev_q
      && (out_slot_q == '0))
    else $error("error word carries payload");
  a_hit_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> out_kind_q == hpc_pkg::KIND_FIND)
    else $error("hit on a non-find word");
  a_ev_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ev_q |-> out_kind_q == hpc_pkg::KIND_CLAIM && out_evbuf_q != '0)
    else $error("eviction on a non-claim word");
`endif

endmodule

// File: hdl/hpc_ctrl.sv
// Controller state machine: sequences key loads, payload sets, probe walks and key copies.
module hpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  output logic          in_ready_o,
  input  hpc_pkg::sts_t sts_i,
  output hpc_pkg::cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FIND  = 13'b0000000000010,
    S_FMETA = 13'b0000000000100,
    S_CRD   = 13'b0000000001000,
    S_CCHK  = 13'b0000000010000,
    S_FREE  = 13'b0000000100000,
    S_LRUA  = 13'b0000001000000,
    S_LRUB  = 13'b0000010000000,
    S_EVA   = 13'b0000100000000,
    S_EVB   = 13'b0001000000000,
    S_WRITE = 13'b0010000000000,
    S_COPY  = 13'b0100000000000,
    S_RESP  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = hpc_pkg::KIND_FIND;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (hpc_pkg::action_e'(action_i))
            hpc_pkg::ACT_KEY: cmd_o.key_load = 1'b1;
            hpc_pkg::ACT_SET: cmd_o.set_load = 1'b1;
            hpc_pkg::ACT_FIND: begin
              cmd_o.op_start = 1'b1;
              cmd_o.kind     = sts_i.ovf ? hpc_pkg::KIND_ERR : hpc_pkg::KIND_FIND;
              state_d        = sts_i.ovf ? S_RESP : S_FIND;
            end
            hpc_pkg::ACT_CLAIM: begin
              cmd_o.op_start = 1'b1;
              cmd_o.kind     = sts_i.ovf ? hpc_pkg::KIND_ERR : hpc_pkg::KIND_CLAIM;
              state_d        = sts_i.ovf ? S_RESP : S_FREE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        // The walk ends at the window's end or at the first unused slot.
        state_d = (sts_i.probe_end || !sts_i.used_cur) ? S_RESP : S_FMETA;
      end
      S_FMETA: begin
        if (sts_i.meta_match) begin
          cmd_o.j_clear = 1'b1;
          state_d       = S_CRD;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_FIND;
        end
      end
      S_CRD: begin
        if (sts_i.j_end) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_RESP;
        end else begin
          state_d = S_CCHK;
        end
      end
      S_CCHK: begin
        if (sts_i.byte_eq) begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_CRD;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_FIND;
        end
      end
      S_FREE: begin
        if (sts_i.probe_end) begin
          cmd_o.lru_init = 1'b1;
          state_d        = S_LRUA;
        end else if (!sts_i.used_cur) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_LRUA: state_d = S_LRUB;
      S_LRUB: begin
        cmd_o.lru_step = 1'b1;
        state_d        = sts_i.lru_last ? S_EVA : S_LRUA;
      end
      S_EVA: state_d = S_EVB;
      S_EVB: begin
        cmd_o.ev_check = 1'b1;
        state_d        = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.claim_write = 1'b1;
        state_d           = S_COPY;
      end
      S_COPY: begin
        if (sts_i.copy_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.copy_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/hashed_probe_cache_lru_core.sv
// Top level of the hashed probe cache: stream ports, controller and datapath.
// Key byte and set words are accepted one per cycle while no find or claim is in progress.
// Find walks the probed slots and compares key bytes, bound by the registered slot-store
// and key-store reads; claim takes a free slot or the least recently used, then copies the key.
// Reset clears the key state and the used marks (flip-flops); no clearing pass is needed.
module hashed_probe_cache_lru_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_byte[7:0], frame[39:8], slot[45:40], buffer_id[77:46], vertex_count[108:78]
  input  logic [111:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], slot_index[6:1], hit_buffer_id[38:7], hit_vertex_count[69:39],
  // evicted_valid[70], evicted_buffer_id[102:71]
  output logic [103:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser
);

  hpc_pkg::cmd_t cmd;
  hpc_pkg::sts_t sts;

  logic        hit, ev_valid;
  logic [5:0]  slot_index;
  logic [31:0] hit_buf, ev_buf;
  logic [30:0] hit_vc;

  hpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_byte_i     (s_axis_tdata[7:0]),
    .frame_i        (s_axis_tdata[39:8]),
    .slot_i         (s_axis_tdata[45:40]),
    .buffer_id_i    (s_axis_tdata[77:46]),
    .vertex_count_i (s_axis_tdata[108:78]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_kind_o     (m_axis_tuser),
    .out_hit_o      (hit),
    .out_slot_o     (slot_index),
    .out_buf_o      (hit_buf),
    .out_vc_o       (hit_vc),
    .out_ev_valid_o (ev_valid),
    .out_ev_buf_o   (ev_buf)
  );

  assign m_axis_tdata = {1'b0, ev_buf, ev_valid, hit_vc, hit_buf, slot_index, hit};

endmodule

// File: test/hashed_probe_cache_lru_core_checker.sv
// Checker for the hashed probe cache: predicts every answer and compares it with the output stream.
module hashed_probe_cache_lru_core_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           err_count_o,
  output int           answers_left_o,
  output int           hit_count_o,
  output int           evict_count_o
);

  typedef struct packed {
    hpc_pkg::kind_e kind;
    logic           hit;
    logic [5:0]     slot;
    logic [31:0]    hit_buf;
    logic [30:0]    hit_vert;
    logic           ev_valid;
    logic [31:0]    ev_buf;
  } answer_t;

  answer_t     answer_q[$];

  logic        used_mark[hpc_pkg::CACHE_SLOTS];
  logic [31:0] stored_hash[hpc_pkg::CACHE_SLOTS];
  int          stored_len[hpc_pkg::CACHE_SLOTS];
  logic [7:0]  stored_key[hpc_pkg::CACHE_SLOTS][hpc_pkg::KEY_ROOM];
  logic [31:0] stamp_frame[hpc_pkg::CACHE_SLOTS];
  logic [31:0] payload_buf[hpc_pkg::CACHE_SLOTS];
  logic [30:0] payload_vert[hpc_pkg::CACHE_SLOTS];
  logic [31:0] key_hash;
  logic [7:0]  key_bytes[hpc_pkg::KEY_ROOM];
  int          key_len;
  logic        key_overflow;
  logic        key_done;

  task automatic report(input string what, input logic [103:0] got, input answer_t want);
    $display("mismatch: %s  got tuser=%0d tdata=%h  want %p", what, m_axis_tuser, got, want);
    err_count_o++;
  endtask

  function automatic logic same_key(input int s);
    logic ok;
    ok = used_mark[s] && stored_hash[s] == key_hash && stored_len[s] == key_len;
    for (int i = 0; i < hpc_pkg::KEY_ROOM; i++)
      if (ok && i < key_len && stored_key[s][i] != key_bytes[i]) ok = 0;
    return ok;
  endfunction

  task automatic cache_step(input hpc_pkg::action_e act, input logic [111:0] d);
    logic [31:0] frame;
    answer_t     ans;
    int          home, s, pick;
    logic        free_found;
    frame = d[39:8];
    ans = '0;
    case (act)
      hpc_pkg::ACT_KEY: begin
        if (key_done) begin
          key_hash = hpc_pkg::FNV_BASIS;
          key_len = 0;
          key_overflow = 0;
          key_done = 0;
        end
        if (!key_overflow) begin
          if (key_len >= hpc_pkg::KEY_LIMIT) begin
            key_overflow = 1;
          end else begin
            key_bytes[key_len] = d[7:0];
            key_len++;
            key_hash = (key_hash ^ {24'd0, d[7:0]}) * hpc_pkg::FNV_PRIME;
          end
        end
      end
      hpc_pkg::ACT_SET: begin
        payload_buf[d[45:40]] = d[77:46];
        payload_vert[d[45:40]] = d[108:78];
      end
      default: begin
        key_done = 1;
        home = key_hash % hpc_pkg::CACHE_SLOTS;
        if (key_overflow) begin
          ans.kind = hpc_pkg::KIND_ERR;
        end else if (act == hpc_pkg::ACT_FIND) begin
          ans.kind = hpc_pkg::KIND_FIND;
          for (int i = 0; i < hpc_pkg::PROBE_WINDOW; i++) begin
            s = (home + i) % hpc_pkg::CACHE_SLOTS;
            if (!used_mark[s]) break;
            if (same_key(s)) begin
              stamp_frame[s] = frame;
              ans.hit = 1;
              ans.slot = s[5:0];
              ans.hit_buf = payload_buf[s];
              ans.hit_vert = payload_vert[s];
              hit_count_o++;
              break;
            end
          end
        end else begin
          ans.kind = hpc_pkg::KIND_CLAIM;
          free_found = 0;
          pick = home;
          for (int i = 0; i < hpc_pkg::PROBE_WINDOW; i++) begin
            s = (home + i) % hpc_pkg::CACHE_SLOTS;
            if (!free_found && !used_mark[s]) begin
              pick = s;
              free_found = 1;
            end
          end
          if (!free_found) begin
            // Least recently used: smallest signed frame, earliest slot on a tie.
            for (int i = 1; i < hpc_pkg::PROBE_WINDOW; i++) begin
              s = (home + i) % hpc_pkg::CACHE_SLOTS;
              if ($signed(stamp_frame[s]) < $signed(stamp_frame[pick])) pick = s;
            end
            if (used_mark[pick] && payload_buf[pick] != 0) begin
              ans.ev_valid = 1;
              ans.ev_buf = payload_buf[pick];
              evict_count_o++;
            end
          end
          used_mark[pick] = 1;
          stored_hash[pick] = key_hash;
          stored_len[pick] = key_len;
          for (int i = 0; i < hpc_pkg::KEY_ROOM; i++) stored_key[pick][i] = key_bytes[i];
          payload_buf[pick] = '0;
          payload_vert[pick] = '0;
          stamp_frame[pick] = frame;
          ans.slot = pick[5:0];
        end
        answer_q.push_back(ans);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      for (int s = 0; s < hpc_pkg::CACHE_SLOTS; s++) begin
        used_mark[s] = 0;
        stored_hash[s] = '0;
        stored_len[s] = 0;
        stamp_frame[s] = '0;
        payload_buf[s] = '0;
        payload_vert[s] = '0;
      end
      key_hash = hpc_pkg::FNV_BASIS;
      key_len = 0;
      key_overflow = 0;
      key_done = 0;
      err_count_o = 0;
      answers_left_o = 0;
      hit_count_o = 0;
      evict_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          report("answer with none expected", m_axis_tdata, '0);
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tuser != want.kind) report("kind", m_axis_tdata, want);
          if (m_axis_tdata[0] != want.hit) report("hit", m_axis_tdata, want);
          if (m_axis_tdata[6:1] != want.slot) report("slot_index", m_axis_tdata, want);
          if (m_axis_tdata[38:7] != want.hit_buf) report("hit_buffer_id", m_axis_tdata, want);
          if (m_axis_tdata[69:39] != want.hit_vert)
            report("hit_vertex_count", m_axis_tdata, want);
          if (m_axis_tdata[70] != want.ev_valid) report("evicted_valid", m_axis_tdata, want);
          if (m_axis_tdata[102:71] != want.ev_buf)
            report("evicted_buffer_id", m_axis_tdata, want);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        cache_step(hpc_pkg::action_e'(s_axis_tuser), s_axis_tdata);
      answers_left_o = answer_q.size();
    end
  end

endmodule

// File: test/hashed_probe_cache_lru_core_test.sv
// Testbench top of the hashed probe cache: stimulus, receiver stalls and the verdict.
module hashed_probe_cache_lru_core_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL = 48;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = hpc_pkg::ACT_KEY;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int err_count, answers_left, hit_count, evict_count;
  int cycles = 0, words_sent = 0, lookups_sent = 0, burst_left = 0;
  logic [31:0] frame_now = 32'd1;
  logic [7:0]  pool_key[POOL][hpc_pkg::KEY_ROOM];
  int          pool_len[POOL];

  hashed_probe_cache_lru_core u_dut (.*);

  hashed_probe_cache_lru_core_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .err_count_o(err_count), .answers_left_o(answers_left),
    .hit_count_o(hit_count), .evict_count_o(evict_count)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d answers outstanding", answers_left);
      $display("hashed_probe_cache_lru_core_test: errors");
      $finish;
    end
  end

  // The receiver alternates between always-ready stretches and random stalls.
  always @(posedge clk_i) begin
    if (((cycles / 300) % 3) == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  // Drives one word and holds it until the block takes it.
  task automatic send_word(input hpc_pkg::action_e act, input logic [7:0] kb,
                           input logic [5:0] sl, input logic [31:0] bid,
                           input logic [30:0] vc);
    logic took;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {3'b000, vc, bid, sl, frame_now, kb};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
    if (act == hpc_pkg::ACT_FIND || act == hpc_pkg::ACT_CLAIM) lookups_sent++;
  endtask

  task automatic lookup(input hpc_pkg::action_e act);
    if ($urandom_range(0, 19) == 0) frame_now = $urandom;
    else frame_now = frame_now + $urandom_range(0, 3);
    send_word(act, 8'($urandom), 6'($urandom), $urandom, 31'($urandom));
  endtask

  task automatic set_payload(input logic [5:0] sl, input logic [31:0] bid,
                             input logic [30:0] vc);
    send_word(hpc_pkg::ACT_SET, 8'($urandom), sl, bid, vc);
  endtask

  task automatic key_word(input logic [7:0] kb);
    send_word(hpc_pkg::ACT_KEY, kb, 6'($urandom), $urandom, 31'($urandom));
  endtask

  initial begin
    int k, pick;
    for (k = 0; k < POOL; k++) begin
      pick = $urandom_range(0, 9);
      pool_len[k] = pick < 7 ? $urandom_range(1, 30)
                  : pick < 9 ? $urandom_range(24, 48)
                  : $urandom_range(49, hpc_pkg::KEY_LIMIT);
      for (int i = 0; i < hpc_pkg::KEY_ROOM; i++) pool_key[k][i] = 8'($urandom);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the empty key, payload extremes, frame extremes, short keys.
    frame_now = 32'h8000_0000;
    send_word(hpc_pkg::ACT_FIND, 8'h00, 6'd0, '0, '0);
    send_word(hpc_pkg::ACT_CLAIM, 8'hFF, 6'd63, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    set_payload(6'(hpc_pkg::FNV_BASIS % hpc_pkg::CACHE_SLOTS), 32'hFFFF_FFFF,
                31'h7FFF_FFFF);
    frame_now = 32'h7FFF_FFFF;
    send_word(hpc_pkg::ACT_FIND, 8'h00, 6'd0, '0, '0);
    set_payload(6'd63, 32'd0, 31'd0);
    set_payload(6'd0, 32'h8000_0001, 31'h4000_0000);
    key_word(8'h00);
    key_word(8'hFF);
    lookup(hpc_pkg::ACT_FIND);
    lookup(hpc_pkg::ACT_CLAIM);
    lookup(hpc_pkg::ACT_FIND);
    key_word(8'hA5);
    set_payload(6'd17, 32'h1234_5678, 31'h0000_0001);
    lookup(hpc_pkg::ACT_CLAIM);
    frame_now = 32'd0;

    while (words_sent < 1400 || lookups_sent < 60) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        k = $urandom_range(0, POOL - 1);
        for (int i = 0; i < pool_len[k]; i++) key_word(pool_key[k][i]);
        lookup(hpc_pkg::ACT_FIND);
        if ($urandom_range(0, 1)) lookup(hpc_pkg::ACT_CLAIM);
        if ($urandom_range(0, 2) != 0)
          set_payload(6'($urandom), ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom,
                      31'($urandom));
        if ($urandom_range(0, 3) == 0) lookup(hpc_pkg::ACT_FIND);
      end else if (pick < 80) begin
        // Overlong key: one or more bytes past the limit get dropped.
        for (int i = 0; i < hpc_pkg::KEY_LIMIT + $urandom_range(1, 6); i++)
          key_word(8'($urandom));
        lookup($urandom_range(0, 1) ? hpc_pkg::ACT_FIND : hpc_pkg::ACT_CLAIM);
        if ($urandom_range(0, 1)) lookup(hpc_pkg::ACT_CLAIM);
      end else if (pick < 88) begin
        // Key interrupted by a payload write, which must not disturb it.
        k = $urandom_range(0, POOL - 1);
        for (int i = 0; i < pool_len[k]; i++) begin
          if (i == pool_len[k] / 2) set_payload(6'($urandom), $urandom, 31'($urandom));
          key_word(pool_key[k][i]);
        end
        lookup(hpc_pkg::ACT_FIND);
      end else begin
        case ($urandom_range(0, 3))
          0: key_word(8'($urandom));
          1: lookup(hpc_pkg::ACT_FIND);
          2: lookup(hpc_pkg::ACT_CLAIM);
          default: set_payload(6'($urandom), $urandom, 31'($urandom));
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;

    while (answers_left != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d words with %0d finds and claims", words_sent, lookups_sent);
    $display("saw %0d hits and %0d evictions of live buffers", hit_count, evict_count);
    if (err_count == 0) $display("hashed_probe_cache_lru_core_test: clean");
    else $display("hashed_probe_cache_lru_core_test: errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/hpc_pkg.sv
hdl/hpc_ram.sv
hdl/hpc_datapath.sv
hdl/hpc_ctrl.sv
hdl/hashed_probe_cache_lru_core.sv
test/hashed_probe_cache_lru_core_checker.sv
test/hashed_probe_cache_lru_core_test.sv
